### design/eoce_pkg.sv
// Shared types and constants for the entity ownership command engine.
package eoce_pkg;
    localparam int MaxRegistrations = 8;

    localparam logic [2:0] REQ_ACQUIRE    = 3'd0;
    localparam logic [2:0] REQ_LOCK       = 3'd1;
    localparam logic [2:0] REQ_REGISTER   = 3'd2;
    localparam logic [2:0] REQ_DEREGISTER = 3'd3;
    localparam logic [2:0] REQ_GET_CONFIG = 3'd4;
    localparam logic [2:0] REQ_REPLIED    = 3'd5;
    localparam logic [2:0] REQ_TIMEOUT    = 3'd6;

    localparam logic [2:0] ST_SUCCESS     = 3'd0;
    localparam logic [2:0] ST_NOT_IMPL    = 3'd1;
    localparam logic [2:0] ST_BAD_ARGS    = 3'd2;
    localparam logic [2:0] ST_ACQUIRED    = 3'd3;
    localparam logic [2:0] ST_LOCKED      = 3'd4;
    localparam logic [2:0] ST_NO_RES      = 3'd5;
    localparam logic [2:0] ST_IN_PROGRESS = 3'd6;

    localparam logic [0:0] CFG_HANDSHAKE = 1'd0;
    localparam logic [0:0] CFG_CONFIG_IX = 1'd1;

    localparam logic [31:0] FLAG_RELEASE = 32'h8000_0000;
    localparam logic [31:0] FLAG_LOW     = 32'h0000_0001;

    localparam logic [4:0] LEN_NONE = 5'd0;
    localparam logic [4:0] LEN_CFG  = 5'd4;
    localparam logic [4:0] LEN_FULL = 5'd16;

    // scan request from sequencer to slot table
    typedef struct packed {
        logic start;
        logic dereg;
    } t_scan_req;

    typedef struct packed {
        logic done;
        logic found;
        logic has_free;
    } t_scan_rsp;
endpackage

### design/eoce_slot_table.sv
// Registration table scanned slot by slot by a shared 64-bit compare.
module eoce_slot_table #(
    parameter int MAX_REG = eoce_pkg::MaxRegistrations
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  eoce_pkg::t_scan_req  i_req,
    input  logic [63:0]          i_id,
    output eoce_pkg::t_scan_rsp  o_rsp
);
    import eoce_pkg::*;
    localparam int IW = (MAX_REG > 1) ? $clog2(MAX_REG) : 1;

    logic [63:0]        r_mem [MAX_REG];
    logic [MAX_REG-1:0] r_valid;
    logic [IW-1:0]      r_ix;
    logic [IW-1:0]      r_free_ix;
    logic               r_busy, r_dereg, r_found, r_has_free, r_done;
    logic [63:0]        r_rd;
    logic               r_rd_ok;   // read data valid for index r_ix
    logic               hit;

    assign hit = r_valid[r_ix] && (r_rd == i_id);
    assign o_rsp = '{done: r_done, found: r_found, has_free: r_has_free};

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_ix];
        if (!r_busy && r_done && !r_dereg && !r_found && r_has_free)
            r_mem[r_free_ix] <= i_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0; r_ix <= '0; r_free_ix <= '0; r_busy <= 1'b0;
            r_dereg <= 1'b0; r_found <= 1'b0; r_has_free <= 1'b0;
            r_done <= 1'b0; r_rd_ok <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1; r_ix <= '0; r_rd_ok <= 1'b0;
                r_dereg <= i_req.dereg; r_found <= 1'b0; r_has_free <= 1'b0;
            end else if (r_busy) begin
                if (!r_rd_ok) begin
                    r_rd_ok <= 1'b1;   // wait for registered read
                end else begin
                    if (hit) begin
                        r_found <= 1'b1;
                        if (r_dereg) r_valid[r_ix] <= 1'b0;
                    end
                    if (!r_valid[r_ix] && !r_has_free) begin
                        r_has_free <= 1'b1; r_free_ix <= r_ix;
                    end
                    r_rd_ok <= 1'b0;
                    if (32'(r_ix) == MAX_REG - 1) begin
                        r_busy <= 1'b0; r_done <= 1'b1;
                    end else begin
                        r_ix <= r_ix + 1'b1;
                    end
                end
            end
            if (!r_busy && r_done && !r_dereg && !r_found && r_has_free)
                r_valid[r_free_ix] <= 1'b1;
        end
    end
endmodule

### design/entity_ownership_command_engine_core.sv
// Top level: command sequencer, ownership state and result register.
//
// Use: present one decoded command on the request channel (i_valid/o_ready
// with the req_type, controller_id and companion fields). Results leave on
// o_valid/i_ready; an item yields zero or one result (pending-handshake
// events with nothing pending give none). Configuration registers are
// written through i_cfg_valid/o_cfg_ready, index 0 handshake_enabled,
// index 1 current_config_index; the user must write them only while the
// engine is idle, as the block itself does not enforce it. Acquire, lock,
// get configuration and events pass through S_EXEC to the result register.
// Register and deregister scan the registration table slot by slot through
// a shared comparator with a registered read, then load the result register.
// o_ready is low from accept until the result is taken.
// A stalled receiver holds the result in the output register.
// Reset clears ownership, lock, pending request and all slot valid bits;
// handshake_enabled returns to one and the config index to zero.
module entity_ownership_command_engine_core #(
    parameter int MAX_REGISTRATIONS = eoce_pkg::MaxRegistrations
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_controller_id,
    input  logic [47:0] i_source_mac,
    input  logic [31:0] i_cmd_flags,
    input  logic [15:0] i_desc_type_in,
    input  logic [15:0] i_desc_index_in,
    input  logic        i_args_short,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_resp_flags,
    output logic [63:0] o_owner_out,
    output logic [15:0] o_desc_type_out,
    output logic [15:0] o_desc_index_out,
    output logic [15:0] o_config_index_out,
    output logic [4:0]  o_body_length,
    output logic [47:0] o_dest_mac,
    output logic        o_late_response,
    output logic        o_query_owner,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import eoce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_EXEC = 4'b0010, S_SCAN = 4'b0100, S_OUT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [2:0]  r_type;
    logic [63:0] r_id;
    logic [47:0] r_mac;
    logic [31:0] r_flags, r_desc;
    logic        r_short;
    logic        r_hs_en;
    logic [15:0] r_cfg_ix;
    logic        r_acq, r_pers, r_locked, r_pend;
    logic [63:0] r_owner, r_lock_owner, r_pend_id;
    logic [47:0] r_pend_mac;
    logic [31:0] r_pend_flags, r_pend_desc;
    t_scan_req   scan_req;
    t_scan_rsp   scan_rsp;

    eoce_slot_table #(.MAX_REG(MAX_REGISTRATIONS)) u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(scan_req), .i_id(r_id),
        .o_rsp(scan_rsp)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = (r_state == S_OUT);
    assign scan_req.start = (r_state == S_EXEC) &&
        (r_type == REQ_REGISTER || r_type == REQ_DEREGISTER);
    assign scan_req.dereg = (r_type == REQ_DEREGISTER);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (scan_req.start) n_state = S_SCAN;
                else if ((r_type == REQ_REPLIED || r_type == REQ_TIMEOUT) && !r_pend)
                    n_state = S_IDLE;
                else n_state = S_OUT;
            end
            S_SCAN: if (scan_rsp.done) n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_type <= i_req_type; r_id <= i_controller_id; r_mac <= i_source_mac;
            r_flags <= i_cmd_flags; r_desc <= {i_desc_type_in, i_desc_index_in};
            r_short <= i_args_short;
        end
    end

    // full-body helper outputs
    logic [31:0] b_flags, b_desc;
    logic [63:0] b_owner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_hs_en <= 1'b1; r_cfg_ix <= '0;
            r_acq <= 1'b0; r_pers <= 1'b0; r_locked <= 1'b0; r_pend <= 1'b0;
            r_owner <= '0; r_lock_owner <= '0; r_pend_id <= '0; r_pend_mac <= '0;
            r_pend_flags <= '0; r_pend_desc <= '0;
            o_status <= '0; o_body_length <= '0; o_late_response <= 1'b0;
            o_query_owner <= 1'b0; o_resp_flags <= '0; o_owner_out <= '0;
            o_desc_type_out <= '0; o_desc_index_out <= '0;
            o_config_index_out <= '0; o_dest_mac <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_HANDSHAKE: r_hs_en <= i_cfg_data[0];
                    CFG_CONFIG_IX: r_cfg_ix <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_SCAN && scan_rsp.done) begin
                o_status <= (r_type == REQ_REGISTER && !scan_rsp.found &&
                             !scan_rsp.has_free) ? ST_NO_RES : ST_SUCCESS;
            end
            if (r_state == S_EXEC) begin
                o_status <= ST_SUCCESS; o_resp_flags <= '0; o_owner_out <= '0;
                o_desc_type_out <= '0; o_desc_index_out <= '0;
                o_config_index_out <= '0; o_body_length <= LEN_NONE;
                o_dest_mac <= r_mac; o_late_response <= 1'b0; o_query_owner <= 1'b0;
                case (r_type)
                    REQ_ACQUIRE: begin
                        if (r_short) o_status <= ST_BAD_ARGS;
                        else begin
                            o_body_length <= LEN_FULL;
                            o_desc_type_out <= r_desc[31:16];
                            o_desc_index_out <= r_desc[15:0];
                            o_resp_flags <= r_flags;
                            o_owner_out <= r_owner;
                            if ((r_flags & FLAG_RELEASE) != '0) begin
                                if (r_acq && r_owner == r_id) begin
                                    r_acq <= 1'b0; r_pers <= 1'b0; r_owner <= '0;
                                    o_resp_flags <= '0; o_owner_out <= '0;
                                end else o_status <= ST_ACQUIRED;
                            end else if (!r_acq) begin
                                r_acq <= 1'b1; r_owner <= r_id;
                                r_pers <= r_flags[0]; o_owner_out <= r_id;
                            end else if (r_owner == r_id) begin
                            end else if (!r_pers && r_hs_en) begin
                                r_pend <= 1'b1; r_pend_id <= r_id; r_pend_mac <= r_mac;
                                r_pend_flags <= r_flags; r_pend_desc <= r_desc;
                                o_status <= ST_IN_PROGRESS; o_query_owner <= 1'b1;
                                o_body_length <= LEN_NONE; o_resp_flags <= '0;
                                o_desc_type_out <= '0; o_desc_index_out <= '0;
                            end else o_status <= ST_ACQUIRED;
                        end
                    end
                    REQ_LOCK: begin
                        if (r_short) o_status <= ST_BAD_ARGS;
                        else begin
                            o_body_length <= LEN_FULL;
                            o_desc_type_out <= r_desc[31:16];
                            o_desc_index_out <= r_desc[15:0];
                            o_resp_flags <= r_flags;
                            if ((r_flags & FLAG_LOW) != '0) begin
                                if (r_locked && r_lock_owner == r_id) begin
                                    r_locked <= 1'b0; r_lock_owner <= '0;
                                end else if (r_locked) begin
                                    o_status <= ST_LOCKED; o_owner_out <= r_lock_owner;
                                end
                            end else if (!r_locked) begin
                                r_locked <= 1'b1; r_lock_owner <= r_id; o_owner_out <= r_id;
                            end else begin
                                o_owner_out <= r_lock_owner;
                                if (r_lock_owner != r_id) o_status <= ST_LOCKED;
                            end
                        end
                    end
                    REQ_REGISTER, REQ_DEREGISTER: ;
                    REQ_GET_CONFIG: begin
                        o_config_index_out <= r_cfg_ix; o_body_length <= LEN_CFG;
                    end
                    REQ_REPLIED, REQ_TIMEOUT: begin
                        o_body_length <= LEN_FULL; o_resp_flags <= b_flags;
                        o_desc_type_out <= b_desc[31:16];
                        o_desc_index_out <= b_desc[15:0];
                        o_dest_mac <= r_pend_mac; o_late_response <= 1'b1;
                        o_owner_out <= b_owner;
                        if (r_type == REQ_REPLIED) o_status <= ST_ACQUIRED;
                        else if (r_pend) begin
                            r_acq <= 1'b1; r_owner <= r_pend_id;
                            r_pers <= r_pend_flags[0];
                        end
                        if (r_pend) begin
                            r_pend <= 1'b0; r_pend_id <= '0; r_pend_mac <= '0;
                            r_pend_flags <= '0; r_pend_desc <= '0;
                        end
                    end
                    default: o_status <= ST_NOT_IMPL;
                endcase
            end
        end
    end

    assign b_flags = r_pend_flags;
    assign b_desc  = r_pend_desc;
    assign b_owner = (r_type == REQ_TIMEOUT) ? r_pend_id : r_owner;
endmodule
